>>> design/htlp_pkg.sv
// Shared constants and types for the linear-probing hash table.
package htlp_pkg;

  localparam int TABLE_SIZE = 8;
  localparam int SLOT_W     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int KEY_W      = 31;
  localparam int OUT_SLOT_W = 3;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

endpackage

>>> design/htlp_req_if.sv
// Request channel: operation and key.
interface htlp_req_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [htlp_pkg::KEY_W-1:0] key;

  modport source (output valid, op, key, input ready);
  modport sink   (input valid, op, key, output ready);
endinterface

>>> design/htlp_rsp_if.sv
// Response channel: status and slot index.
interface htlp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [htlp_pkg::OUT_SLOT_W-1:0] slot;

  modport source (output valid, status, slot, input ready);
  modport sink   (input valid, status, slot, output ready);
endinterface

>>> design/hash_table_linear_probing.sv
// Open-addressing hash table with linear probing over a synchronous key memory.
//
// Each request inserts or looks up a key. The home slot is the key modulo
// TABLE_SIZE, and probing steps one slot per cycle with wrap. The read of the
// home slot is issued in the transfer cycle, and a result is loaded after at
// most TABLE_SIZE probes, each bounded by the single read port of the key memory.
// The next request is taken in the cycle after the result is loaded, so the
// block takes no new request while an earlier one is still being probed.
// Loading a result holds while an earlier result waits in the output register.
// Occupancy bits live in flip-flops and clear on reset, so the table is usable
// in the first cycle after reset. A new request is taken while an earlier
// result still waits in the output register.
module hash_table_linear_probing (
  input  logic            clk,
  input  logic            rst,
  htlp_req_if.sink        req,
  htlp_rsp_if.source      rsp
);

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_t;

  state_t                           state;
  logic                             op;
  logic [htlp_pkg::KEY_W-1:0]       key;
  logic [htlp_pkg::SLOT_W-1:0]      pos;
  logic [htlp_pkg::SLOT_W-1:0]      cnt;
  logic [htlp_pkg::TABLE_SIZE-1:0]  slot_valid;
  logic [htlp_pkg::KEY_W-1:0]       slot_key [htlp_pkg::TABLE_SIZE];
  logic [htlp_pkg::KEY_W-1:0]       rd_key;
  logic [htlp_pkg::SLOT_W-1:0]      rd_addr;
  logic [htlp_pkg::SLOT_W-1:0]      pos_next;
  logic [htlp_pkg::SLOT_W-1:0]      home;
  logic                             out_free;
  logic                             hit_empty;
  logic                             hit_match;
  logic                             last_probe;
  logic                             done;
  logic                             finish;
  logic                             wr_en;
  htlp_pkg::status_t                res_status;
  htlp_pkg::status_t                status;
  logic [htlp_pkg::OUT_SLOT_W-1:0]  res_slot;
  logic [htlp_pkg::OUT_SLOT_W-1:0]  slot;
  logic                             rsp_valid;

  assign home     = htlp_pkg::SLOT_W'(req.key % htlp_pkg::KEY_W'(htlp_pkg::TABLE_SIZE));
  assign pos_next = (pos == htlp_pkg::SLOT_W'(htlp_pkg::TABLE_SIZE - 1)) ?
                    '0 : pos + htlp_pkg::SLOT_W'(1);
  assign out_free   = !rsp_valid || rsp.ready;
  assign hit_empty  = !slot_valid[pos];
  assign hit_match  = (op == htlp_pkg::OP_FIND) && !hit_empty && (rd_key == key);
  assign last_probe = (cnt == htlp_pkg::SLOT_W'(htlp_pkg::TABLE_SIZE - 1));
  assign done       = hit_empty || hit_match || last_probe;
  assign finish     = (state == S_PROBE) && done && out_free;
  assign wr_en      = finish && (op == htlp_pkg::OP_INSERT) && hit_empty;

  always_comb begin
    res_slot = '0;
    if (hit_empty) begin
      if (op == htlp_pkg::OP_INSERT) begin
        res_status = htlp_pkg::ST_INSERTED;
        res_slot   = htlp_pkg::OUT_SLOT_W'({{htlp_pkg::OUT_SLOT_W{1'b0}}, pos});
      end else begin
        res_status = htlp_pkg::ST_NOT_FOUND;
      end
    end else if (hit_match) begin
      res_status = htlp_pkg::ST_FOUND;
      res_slot   = htlp_pkg::OUT_SLOT_W'({{htlp_pkg::OUT_SLOT_W{1'b0}}, pos});
    end else if (op == htlp_pkg::OP_INSERT) begin
      res_status = htlp_pkg::ST_FULL;
    end else begin
      res_status = htlp_pkg::ST_NOT_FOUND;
    end
  end

  always_comb begin
    case (state)
      S_IDLE:  rd_addr = home;
      S_PROBE: rd_addr = done ? pos : pos_next;
      default: rd_addr = pos;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_key <= slot_key[rd_addr];
    if (wr_en) begin
      slot_key[pos] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      if (rsp.ready && !finish) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op    <= req.op;
            key   <= req.key;
            pos   <= home;
            cnt   <= '0;
            state <= S_PROBE;
          end
        end
        S_PROBE: begin
          if (finish) begin
            rsp_valid <= 1'b1;
            status    <= res_status;
            slot      <= res_slot;
            state     <= S_IDLE;
            if (wr_en) begin
              slot_valid[pos] <= 1'b1;
            end
          end else if (!done) begin
            pos <= pos_next;
            cnt <= cnt + htlp_pkg::SLOT_W'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = rsp_valid;
  assign rsp.status = status;
  assign rsp.slot   = slot;

`ifndef SYNTHESIS
  a_insert_marks_slot: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> slot_valid[$past(pos)])
    else $error("Inserted slot was not marked occupied.");

  a_occupancy_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ($countones(slot_valid) >= $countones($past(slot_valid))))
    else $error("Occupied slot count decreased without reset.");

  a_found_matches: assert property (@(posedge clk) disable iff (rst)
    (finish && (res_status == htlp_pkg::ST_FOUND)) |-> (slot_valid[pos] && (rd_key == key)))
    else $error("Found result without a matching occupied slot.");
`endif

endmodule
